### hdl/sdft_pkg.sv
`default_nettype none
package sdft_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int ADDR_W            = 48;
    localparam int SEQ_W             = 16;
    localparam int TIME_W            = 32;
    localparam int TIMEOUT_W         = 16;
    localparam int PURGE_W           = 5;
    localparam int IN_DATA_W         = 96;
    localparam int OUT_DATA_W        = 8;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [SEQ_W-1:0]     WRAP_LIMIT    = 16'd32768;
    localparam logic [PURGE_W-1:0]   PURGE_MAX     = 5'd31;

    // Item kinds carried on the input tuser.
    localparam logic OP_PACKET  = 1'b0;
    localparam logic OP_CLEANUP = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } sdft_state_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] stamp;
    } sdft_entry_t;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] now;
    } sdft_item_t;

    typedef struct packed {
        logic match;
        logic newer;
        logic expired;
    } sdft_cmp_t;

    typedef struct packed {
        logic [PURGE_W-1:0] purged_count;
        logic               table_full;
        logic               new_source;
        logic               accepted;
    } sdft_result_t;

endpackage
`default_nettype wire

### hdl/sdft_mem.sv
`default_nettype none
module sdft_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [IDX_W-1:0]     wr_idx,
    input  wire sdft_pkg::sdft_entry_t wr_entry,
    input  wire logic [IDX_W-1:0]     rd_idx,
    output sdft_pkg::sdft_entry_t     rd_entry
);
    import sdft_pkg::*;

    sdft_entry_t mem [DEPTH];
    sdft_entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_entry_reg <= mem[rd_idx];
    end

    assign rd_entry = rd_entry_reg;

endmodule
`default_nettype wire

### hdl/sdft_unit.sv
`default_nettype none
module sdft_unit (
    input  wire sdft_pkg::sdft_entry_t    entry,
    input  wire sdft_pkg::sdft_item_t     item,
    input  wire logic [sdft_pkg::TIMEOUT_W-1:0] timeout_ms,
    output sdft_pkg::sdft_cmp_t           cmp
);
    import sdft_pkg::*;

    logic [SEQ_W:0]    seq_diff;
    logic [TIME_W-1:0] age;

    always_comb
    begin
        // Stored minus new as a signed value; the top bit set means stored < new.
        seq_diff = {1'b0, entry.seq} - {1'b0, item.seq};
        age      = item.now - entry.stamp;

        cmp.match   = entry.valid && (entry.addr == item.addr);
        cmp.newer   = seq_diff[SEQ_W] || (seq_diff[SEQ_W-1:0] > WRAP_LIMIT);
        cmp.expired = entry.valid && (age > {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_ms});
    end

endmodule
`default_nettype wire

### hdl/sdft_seq.sv
`default_nettype none
module sdft_seq #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire sdft_pkg::sdft_item_t  s_item,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output sdft_pkg::sdft_result_t     m_result,
    output sdft_pkg::sdft_item_t       key,
    input  wire sdft_pkg::sdft_entry_t rd_entry,
    input  wire sdft_pkg::sdft_cmp_t   cmp,
    output logic [IDX_W-1:0]           rd_idx,
    output logic                       wr_en,
    output logic [IDX_W-1:0]           wr_idx,
    output sdft_pkg::sdft_entry_t      wr_entry
);
    import sdft_pkg::*;

    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(DEPTH - 1);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);

    sdft_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   issue_cnt_reg, issue_cnt_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               hit_reg, hit_next;
    logic               hit_newer_reg, hit_newer_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic               free_reg, free_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [PURGE_W-1:0] count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    sdft_result_t       out_reg, out_next;
    sdft_item_t         item_reg, item_next;
    logic               load_out;
    logic               take_in;

    assign s_tready = (state_reg == ST_IDLE);
    assign take_in  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;
    assign key      = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            issue_cnt_reg <= '0;
            chk_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            chk_valid_reg <= chk_valid_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg   <= chk_idx_next;
        hit_newer_reg <= hit_newer_next;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        out_reg       <= out_next;
        item_reg      <= item_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        hit_next       = hit_reg;
        hit_newer_next = hit_newer_reg;
        hit_idx_next   = hit_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        count_next     = count_reg;
        out_next       = out_reg;
        item_next      = item_reg;
        load_out       = 1'b0;
        rd_idx         = '0;
        wr_en          = 1'b0;
        wr_idx         = chk_idx_reg;
        wr_entry       = rd_entry;
        wr_entry.valid = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero one entry a cycle so that every valid bit starts cleared.
                wr_en          = 1'b1;
                wr_idx         = issue_cnt_reg[IDX_W-1:0];
                wr_entry       = '0;
                issue_cnt_next = issue_cnt_reg + 1'b1;
                if (issue_cnt_reg == CNT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (take_in)
                begin
                    item_next      = s_item;
                    issue_cnt_next = '0;
                    hit_next       = 1'b0;
                    free_next      = 1'b0;
                    count_next     = '0;
                    state_next     = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Reads are issued one entry ahead of the check that uses them.
                if (issue_cnt_reg < CNT_DEPTH)
                begin
                    rd_idx         = issue_cnt_reg[IDX_W-1:0];
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_cnt_reg[IDX_W-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end

                if (chk_valid_reg)
                begin
                    if (item_reg.op == OP_CLEANUP)
                    begin
                        if (cmp.expired)
                        begin
                            wr_en = 1'b1;
                            if (count_reg != PURGE_MAX)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        if (cmp.match && !hit_reg)
                        begin
                            hit_next       = 1'b1;
                            hit_idx_next   = chk_idx_reg;
                            hit_newer_next = cmp.newer;
                        end
                        if (!rd_entry.valid && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = chk_idx_reg;
                        end
                    end

                    if (chk_idx_reg == IDX_LAST)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out = 1'b1;
                    out_next = '0;
                    if (item_reg.op == OP_CLEANUP)
                    begin
                        out_next.purged_count = count_reg;
                    end
                    else if (hit_reg)
                    begin
                        out_next.accepted = hit_newer_reg;
                        wr_en             = hit_newer_reg;
                        wr_idx            = hit_idx_reg;
                    end
                    else if (free_reg)
                    begin
                        out_next.accepted   = 1'b1;
                        out_next.new_source = 1'b1;
                        wr_en               = 1'b1;
                        wr_idx              = free_idx_reg;
                    end
                    else
                    begin
                        out_next.table_full = 1'b1;
                    end
                    if (item_reg.op == OP_PACKET)
                    begin
                        wr_entry.valid = 1'b1;
                        wr_entry.addr  = item_reg.addr;
                        wr_entry.seq   = item_reg.seq;
                        wr_entry.stamp = item_reg.now;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        take_in |=> !s_tready)
        else $error("input still ready after an item was taken");

    a_scan_write_cleanup: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && wr_en) |-> (item_reg.op == OP_CLEANUP))
        else $error("table written during a packet lookup");

    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !(out_next.accepted && out_next.table_full)
                     && (!out_next.new_source || out_next.accepted))
        else $error("inconsistent result flags");

    a_finish_write_recorded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && wr_en) |-> (load_out && out_next.accepted))
        else $error("table updated for a packet that was not accepted");

endmodule
`default_nettype wire

### hdl/sequence_duplicate_filter_table.sv
`default_nettype none
// Channel  Dir  Handshake           Payload
// s        in   s_tvalid/s_tready   tuser: operation; tdata: src_address, seq_number, now_ms
// m        out  m_tvalid/m_tready   tdata: accepted, new_source, table_full, purged_count
// cfg      in   cfg_we              cfg_wdata: timeout_ms
//
// Every item walks the whole table through the single read port of the entry memory,
// one entry per cycle, before its result is loaded into the result register.
// After reset a clearing pass zeroes the table entry by entry; s_tready stays low
// until it ends. The result register holds one finished item; a stalled m_tready
// only holds the block in its final step until that register is free.
module sequence_duplicate_filter_table #(
    parameter int TABLE_ENTRIES = sdft_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // Bits up from 0: src_address[47:0], seq_number[63:48], now_ms[95:64].
    input  wire logic [sdft_pkg::IN_DATA_W-1:0]    s_tdata,
    // Bit 0: operation.
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // Bits up from 0: accepted, new_source, table_full, purged_count[7:3].
    output logic [sdft_pkg::OUT_DATA_W-1:0]        m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [sdft_pkg::TIMEOUT_W-1:0]    cfg_wdata
);
    import sdft_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic [TIMEOUT_W-1:0] timeout_reg;
    sdft_item_t           s_item;
    sdft_item_t           key;
    sdft_result_t         m_result;
    sdft_entry_t          rd_entry;
    sdft_entry_t          wr_entry;
    sdft_cmp_t            cmp;
    logic [IDX_W-1:0]     rd_idx;
    logic [IDX_W-1:0]     wr_idx;
    logic                 wr_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        s_item.op   = s_tuser;
        s_item.addr = s_tdata[ADDR_W-1:0];
        s_item.seq  = s_tdata[ADDR_W+SEQ_W-1:ADDR_W];
        s_item.now  = s_tdata[ADDR_W+SEQ_W+TIME_W-1:ADDR_W+SEQ_W];
    end

    assign m_tdata = {m_result.purged_count, m_result.table_full,
                      m_result.new_source, m_result.accepted};

    sdft_seq #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result),
        .key      (key),
        .rd_entry (rd_entry),
        .cmp      (cmp),
        .rd_idx   (rd_idx),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_entry (wr_entry)
    );

    sdft_mem #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_entry (wr_entry),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry)
    );

    sdft_unit u_unit (
        .entry      (rd_entry),
        .item       (key),
        .timeout_ms (timeout_reg),
        .cmp        (cmp)
    );

endmodule
`default_nettype wire
